[hw/rtl/assert_macros.svh]
// Assertion macros used by the boundary index mapper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (cond) |-> (cons), msg)

`endif

[hw/rtl/bim_pkg.sv]
// Shared types for the boundary index mapper.
package bim_pkg;

  typedef enum logic [1:0] {
    OP_CLIP = 2'd0,
    OP_WRAP = 2'd1,
    OP_FOLD = 2'd2
  } bim_op_e;

  // Control bits that travel with each request down the cell chain.
  typedef struct packed {
    bim_op_e op;
    logic    neg;
    logic    ok;
    logic    fold_one;
  } bim_ctl_t;

endpackage

[hw/rtl/bim_cell.sv]
// One restoring-division cell: consumes one dividend bit per request.
module bim_cell import bim_pkg::*; #(
  parameter int unsigned DW  = 16,
  parameter int unsigned DVW = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  bim_ctl_t       ctl_i,
  input  logic [DW-1:0]  dvd_i,
  input  logic [DVW-1:0] rem_i,
  input  logic [DVW-1:0] div_i,
  output logic           valid_o,
  input  logic           stall_i,
  output bim_ctl_t       ctl_o,
  output logic [DW-1:0]  dvd_o,
  output logic [DVW-1:0] rem_o,
  output logic [DVW-1:0] div_o
);

  logic           valid_q;
  logic           take;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic [DVW-1:0] rem_d;
  logic [DW-1:0]  dvd_d;
  bim_ctl_t       ctl_q;
  logic [DW-1:0]  dvd_q;
  logic [DVW-1:0] rem_q;
  logic [DVW-1:0] div_q;

  // Hold while a stored request waits on a stalled neighbor.
  assign stall_o = valid_q && stall_i;
  assign take    = !stall_o;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_i, dvd_i[DW-1]};
    diff  = trial - {1'b0, div_i};
    rem_d = (trial >= {1'b0, div_i}) ? diff[DVW-1:0] : trial[DVW-1:0];
    dvd_d = {dvd_i[DW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= valid_i;
    end
  end

  // Load payload on each accepted request.
  always_ff @(posedge clk_i) begin
    if (take && valid_i) begin
      ctl_q <= ctl_i;
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      div_q <= div_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dvd_o   = dvd_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;

endmodule

[hw/rtl/boundary_index_mapper.sv]
// Boundary index mapper top level: clip, wrap and fold of a position into a list.
// Pipeline: one division cell per dividend bit, then the output register.
// Throughput: one request per cycle; every cell and the output register hand on
// each cycle, and a stalled output only backs up the cells that are full.
// Reset: asynchronous, active low; clears the valid bit of every stage only.
module boundary_index_mapper import bim_pkg::*; #(
  parameter int unsigned POS_BITS = 16,
  parameter int unsigned LEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [POS_BITS-1:0] pos_i,
  input  logic [LEN_BITS-1:0] length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LEN_BITS-1:0] index_o,
  output logic                valid_res_o
);

  localparam int unsigned DW  = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;
  localparam int unsigned DVW = LEN_BITS + 1;

  logic [DW:0]    vld_s;
  logic [DW:0]    stl_s;
  bim_ctl_t       ctl_s [DW+1];
  logic [DW-1:0]  dvd_s [DW+1];
  logic [DVW-1:0] rem_s [DW+1];
  logic [DVW-1:0] div_s [DW+1];

  logic [POS_BITS-1:0] pos_mag;
  logic [LEN_BITS-1:0] len_m1;
  bim_ctl_t            ctl_in;
  logic [DW-1:0]       dvd_in;
  logic [DVW-1:0]      div_in;

  // Pick dividend and divisor per mode; clip is folded into a remainder by length.
  always_comb begin
    pos_mag         = pos_i[POS_BITS-1] ? (~pos_i + POS_BITS'(1)) : pos_i;
    len_m1          = length_i - LEN_BITS'(1);
    ctl_in.op       = OP_CLIP;
    ctl_in.neg      = pos_i[POS_BITS-1];
    ctl_in.ok       = (length_i != '0);
    ctl_in.fold_one = (length_i == LEN_BITS'(1));
    dvd_in          = '0;
    div_in          = {1'b0, length_i};
    case (operation_i)
      OP_CLIP: begin
        ctl_in.op = OP_CLIP;
        if (pos_i[POS_BITS-1]) begin
          dvd_in = '0;
        end else if (DW'(pos_i) >= DW'(length_i)) begin
          dvd_in = DW'(len_m1);
        end else begin
          dvd_in = DW'(pos_i);
        end
      end
      OP_WRAP: begin
        ctl_in.op = OP_WRAP;
        dvd_in    = DW'(pos_mag);
      end
      OP_FOLD: begin
        ctl_in.op = OP_FOLD;
        dvd_in    = DW'(pos_mag);
        div_in    = {len_m1, 1'b0};
      end
      default: begin
        ctl_in.ok = 1'b0;
      end
    endcase
  end

  assign vld_s[0]   = in_valid_i;
  assign ctl_s[0]   = ctl_in;
  assign dvd_s[0]   = dvd_in;
  assign rem_s[0]   = '0;
  assign div_s[0]   = div_in;
  assign in_stall_o = stl_s[0];

  // Chain of division cells, most significant dividend bit first.
  for (genvar k = 0; k < DW; k++) begin : g_cell
    bim_cell #(
      .DW  (DW),
      .DVW (DVW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[k]),
      .stall_o (stl_s[k]),
      .ctl_i   (ctl_s[k]),
      .dvd_i   (dvd_s[k]),
      .rem_i   (rem_s[k]),
      .div_i   (div_s[k]),
      .valid_o (vld_s[k+1]),
      .stall_i (stl_s[k+1]),
      .ctl_o   (ctl_s[k+1]),
      .dvd_o   (dvd_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .div_o   (div_s[k+1])
    );
  end

  logic           out_valid_q;
  logic [DVW-1:0] rem_f;
  logic [DVW-1:0] comp_f;
  logic [DVW-1:0] idx_f;
  logic [LEN_BITS-1:0] index_q;
  logic                ok_q;

  // Finish each mode from the remainder: floor correction for wrap, mirror for fold, as is for clip.
  always_comb begin
    rem_f  = rem_s[DW];
    comp_f = div_s[DW] - rem_f;
    case (ctl_s[DW].op)
      OP_WRAP: idx_f = (ctl_s[DW].neg && (rem_f != '0)) ? comp_f : rem_f;
      OP_FOLD: begin
        if (ctl_s[DW].fold_one) begin
          idx_f = '0;
        end else begin
          idx_f = (rem_f < comp_f) ? rem_f : comp_f;
        end
      end
      default: idx_f = rem_f;
    endcase
    if (!ctl_s[DW].ok) begin
      idx_f = '0;
    end
  end

  assign stl_s[DW] = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stl_s[DW]) begin
      out_valid_q <= vld_s[DW];
    end
  end

  // Load the result register when the last cell hands on.
  always_ff @(posedge clk_i) begin
    if (vld_s[DW] && !stl_s[DW]) begin
      index_q <= idx_f[LEN_BITS-1:0];
      ok_q    <= ctl_s[DW].ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign valid_res_o = ok_q;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, in_stall_o, &vld_s[DW:1], "stall with empty cell")
  `ASSERT_CLK(a_last_handoff, clk_i, rst_ni, (vld_s[DW] && !stl_s[DW]) |=> out_valid_o, "result lost")
  `ASSERT_IMPLY(a_rem_bound, clk_i, rst_ni, vld_s[DW] && (div_s[DW] != '0), rem_s[DW] < div_s[DW], "remainder not below divisor")
  `ASSERT_IMPLY(a_invalid_zero, clk_i, rst_ni, out_valid_o && !valid_res_o, index_o == '0, "invalid result with nonzero index")
  `ASSERT_IMPLY(a_dvd_spent, clk_i, rst_ni, vld_s[DW], dvd_s[DW] == '0, "dividend bits left over")

endmodule
